// ===== src/swsc_pkg.sv =====
// ----------------------------------------------------------------------------
// swsc_pkg
// Shared types and constants for the sliding-window sender control unit:
// event kinds, action codes, register indexes and channel payload structs.
// ----------------------------------------------------------------------------
package swsc_pkg;

    // Default sequence number width
    localparam int SEQ_BITS_DEF = 16;

    // Fixed field widths
    localparam int ACK_W    = 16;
    localparam int SEQ_W    = 16;
    localparam int FLIGHT_W = 11;
    localparam int WIN_W    = 11;
    localparam int DUP_W    = 4;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [WIN_W-1:0] WINDOW_SIZE_RST   = 11'd4;
    localparam logic [DUP_W-1:0] DUP_THRESHOLD_RST = 4'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUP_THRESHOLD = 2'd1;

    // Event kinds
    typedef enum logic [1:0] {
        KIND_CHUNK   = 2'd0,
        KIND_END     = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    // Result actions
    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_SEND = 3'd1,
        ACT_RETX = 3'd2,
        ACT_FIN  = 3'd3,
        ACT_FULL = 3'd4
    } action_t;

    typedef struct packed {
        kind_t            kind;
        logic [ACK_W-1:0] ack_number;
    } in_item_t;

    typedef struct packed {
        action_t             action;
        logic [SEQ_W-1:0]    seq_number;
        logic [FLIGHT_W-1:0] in_flight;
    } out_item_t;

endpackage

// ===== src/sliding_window_sender_control_unit.sv =====
// ----------------------------------------------------------------------------
// sliding_window_sender_control_unit
// Sender-side window control with cumulative ACKs, fast retransmit on
// duplicate ACKs and timeout retransmit.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one event per transaction (chunk offered, source ended, ACK,
//           timeout). Each event gives exactly one result on out_*.
//   out_* : action, sequence number to (re)send and packets in flight.
//   cfg_* : window_size (index 0) and dup_threshold (index 1); always ready.
//           Write only while no event is pending; the block does not enforce it.
// Each result is registered, in the skid register while an earlier one waits.
// Throughput: one event per cycle while in_ready is high; the window state
//   is updated by one registered pass of compare/increment logic per event.
// The output register is backed by a skid register, so a new event is taken
//   while one result waits; in_ready drops only when both hold a result,
//   i.e. after a waiting result is stalled while a new event is taken.
// Reset: window empty, base and next sequence 0, last ACK all ones, no end
//   known, not finished; window_size 4, dup_threshold 3; no result pending.
// ----------------------------------------------------------------------------
module sliding_window_sender_control_unit #(
    parameter int SEQ_BITS = swsc_pkg::SEQ_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // event channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  swsc_pkg::in_item_t                   in_data,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output swsc_pkg::out_item_t                  out_data,
    // configuration channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [swsc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [swsc_pkg::WIN_W-1:0]           cfg_data
);

    localparam int CMP_W = (SEQ_BITS > swsc_pkg::WIN_W) ? SEQ_BITS : swsc_pkg::WIN_W;
    localparam logic [CMP_W-1:0] FLIGHT_MAX = CMP_W'((1 << swsc_pkg::FLIGHT_W) - 1);

    // configuration registers
    logic [swsc_pkg::WIN_W-1:0] window_size_reg;
    logic [swsc_pkg::DUP_W-1:0] dup_threshold_reg;

    // window state
    logic [SEQ_BITS-1:0]        next_seq_reg, next_seq_next;
    logic [SEQ_BITS-1:0]        window_base_reg, window_base_next;
    logic [SEQ_BITS-1:0]        last_acked_reg, last_acked_next;
    logic [swsc_pkg::DUP_W-1:0] dup_count_reg, dup_count_next;
    logic [SEQ_BITS-1:0]        last_seq_reg, last_seq_next;
    logic                       end_known_reg, end_known_next;
    logic                       finished_reg, finished_next;

    // output and skid buffers
    logic                 out_valid_reg, skid_valid_reg;
    swsc_pkg::out_item_t  out_data_reg, skid_data_reg;

    logic                 in_fire, out_fire;
    swsc_pkg::out_item_t  result;

    // event decode helpers
    logic [SEQ_BITS-1:0]        ack;
    logic [SEQ_BITS-1:0]        ack_inc;
    logic [SEQ_BITS-1:0]        flight_cur;
    logic [SEQ_BITS-1:0]        ack_dist;
    logic [SEQ_BITS-1:0]        flight_new;
    logic [CMP_W-1:0]           flight_ext;
    logic [swsc_pkg::DUP_W:0]   dup_inc;
    logic [SEQ_BITS-1:0]        seq_sel;
    swsc_pkg::action_t          action;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_fire  = out_valid_reg && out_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= swsc_pkg::WINDOW_SIZE_RST;
            dup_threshold_reg <= swsc_pkg::DUP_THRESHOLD_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == swsc_pkg::CFG_WINDOW_SIZE)
                window_size_reg <= cfg_data;
            else if (cfg_index == swsc_pkg::CFG_DUP_THRESHOLD)
                dup_threshold_reg <= cfg_data[swsc_pkg::DUP_W-1:0];
        end
    end

    // per-event window update
    always_comb
    begin
        next_seq_next    = next_seq_reg;
        window_base_next = window_base_reg;
        last_acked_next  = last_acked_reg;
        dup_count_next   = dup_count_reg;
        last_seq_next    = last_seq_reg;
        end_known_next   = end_known_reg;
        finished_next    = finished_reg;
        action           = swsc_pkg::ACT_NONE;
        seq_sel          = '0;

        ack        = SEQ_BITS'(in_data.ack_number);
        ack_inc    = ack + SEQ_BITS'(1);
        flight_cur = next_seq_reg - window_base_reg;
        ack_dist   = ack_inc - window_base_reg;
        dup_inc    = {1'b0, dup_count_reg} + 5'd1;

        if (!finished_reg)
        begin
            unique case (in_data.kind)
                swsc_pkg::KIND_CHUNK:
                begin
                    if (!end_known_reg)
                    begin
                        if (CMP_W'(flight_cur) < CMP_W'(window_size_reg))
                        begin
                            action        = swsc_pkg::ACT_SEND;
                            seq_sel       = next_seq_reg;
                            next_seq_next = next_seq_reg + SEQ_BITS'(1);
                        end
                        else
                            action = swsc_pkg::ACT_FULL;
                    end
                end
                swsc_pkg::KIND_END:
                begin
                    last_seq_next  = next_seq_reg - SEQ_BITS'(1);
                    end_known_next = 1'b1;
                end
                swsc_pkg::KIND_ACK:
                begin
                    priority if (end_known_reg && ack == last_seq_reg)
                    begin
                        finished_next    = 1'b1;
                        window_base_next = ack_inc;
                        action           = swsc_pkg::ACT_FIN;
                    end
                    else if (ack == last_acked_reg)
                    begin
                        // duplicate: retransmit on reaching the threshold, clamp above it
                        if (dup_inc == {1'b0, dup_threshold_reg})
                        begin
                            action         = swsc_pkg::ACT_RETX;
                            seq_sel        = ack_inc;
                            dup_count_next = dup_inc[swsc_pkg::DUP_W-1:0];
                        end
                        else if (dup_inc > {1'b0, dup_threshold_reg})
                            dup_count_next = dup_threshold_reg;
                        else
                            dup_count_next = dup_inc[swsc_pkg::DUP_W-1:0];
                    end
                    else if (ack_dist <= flight_cur)
                    begin
                        // new ACK inside the window; count clears only at threshold
                        window_base_next = ack_inc;
                        last_acked_next  = ack;
                        if (dup_count_reg == dup_threshold_reg)
                            dup_count_next = '0;
                    end
                end
                swsc_pkg::KIND_TIMEOUT:
                begin
                    action  = swsc_pkg::ACT_RETX;
                    seq_sel = last_acked_reg + SEQ_BITS'(1);
                end
                default: ;
            endcase
        end

        // in flight after the step, saturated to the field width
        flight_new = next_seq_next - window_base_next;
        flight_ext = CMP_W'(flight_new);

        result.action     = action;
        result.seq_number = swsc_pkg::SEQ_W'(seq_sel);
        result.in_flight  = (flight_ext > FLIGHT_MAX) ? '1
                                                      : flight_ext[swsc_pkg::FLIGHT_W-1:0];
    end

    // window state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg    <= '0;
            window_base_reg <= '0;
            last_acked_reg  <= '1;
            dup_count_reg   <= '0;
            last_seq_reg    <= '0;
            end_known_reg   <= 1'b0;
            finished_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            next_seq_reg    <= next_seq_next;
            window_base_reg <= window_base_next;
            last_acked_reg  <= last_acked_next;
            dup_count_reg   <= dup_count_next;
            last_seq_reg    <= last_seq_next;
            end_known_reg   <= end_known_next;
            finished_reg    <= finished_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_fire)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= in_fire;
            end
            else if (in_fire)
                skid_valid_reg <= 1'b1;
        end
    end

    // payload of the output and skid registers
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire)
                out_data_reg <= result;
        end
        else if (in_fire)
            skid_data_reg <= result;
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding-window sender control unit. Events go in
// over a valid/ready channel with random gaps, results are taken with random
// stalls, and every result is compared field by field against a behavioral
// window tracker updated on each accepted event. Covers default settings,
// register extremes, back-pressure, random traffic, the largest window and
// the end of a transfer.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 10;
    localparam int GAP_MAX      = 5;
    localparam int HOLD_CYCLES  = 40;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 100;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASES       = 8;
    localparam int LONG_SENDS   = 128;
    localparam int FLIGHT_MAX   = 2047;

    // index with no register behind it
    localparam logic [swsc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    swsc_pkg::in_item_t             in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    swsc_pkg::out_item_t            out_data;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [swsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [swsc_pkg::WIN_W-1:0]     cfg_data = '0;

    // window tracker state
    logic [swsc_pkg::WIN_W-1:0] cur_window;
    logic [swsc_pkg::DUP_W-1:0] cur_dup_limit;
    logic [swsc_pkg::SEQ_W-1:0] tx_next;
    logic [swsc_pkg::SEQ_W-1:0] tx_base;
    logic [swsc_pkg::SEQ_W-1:0] tx_last_ack;
    logic [swsc_pkg::SEQ_W-1:0] tx_last;
    logic [swsc_pkg::DUP_W-1:0] tx_dups;
    bit                         tx_end_seen;
    bit                         tx_done;

    swsc_pkg::out_item_t pending_actions[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        tx_gap_max = GAP_MAX;
    int        rx_stall_max = GAP_MAX;
    int        rx_hold = 0;

    sliding_window_sender_control_unit uut (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .in_data,
        .out_valid,
        .out_ready,
        .out_data,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    always #(CLK_HALF) clk = ~clk;

    // Watchdog: no transaction on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        // keep the log bounded on a badly broken build
        if (mismatch_count <= REPORT_LIMIT)
            $display("tb: mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic reset_window_state();
        cur_window    = swsc_pkg::WINDOW_SIZE_RST;
        cur_dup_limit = swsc_pkg::DUP_THRESHOLD_RST;
        tx_next       = '0;
        tx_base       = '0;
        tx_last_ack   = '1;
        tx_last       = '0;
        tx_dups       = '0;
        tx_end_seen   = 1'b0;
        tx_done       = 1'b0;
    endtask

    // Apply one event to the window tracker and return the expected result
    function automatic swsc_pkg::out_item_t next_window_action(input swsc_pkg::in_item_t ev);
        swsc_pkg::out_item_t        res;
        logic [swsc_pkg::SEQ_W-1:0] new_base;
        logic [swsc_pkg::SEQ_W-1:0] span;
        logic [swsc_pkg::SEQ_W-1:0] reach;
        logic [swsc_pkg::DUP_W:0]   dups;
        res.action     = swsc_pkg::ACT_NONE;
        res.seq_number = '0;
        new_base = ev.ack_number + 1'b1;
        span     = tx_next - tx_base;
        reach    = new_base - tx_base;
        if (!tx_done)
        begin
            case (ev.kind)
                swsc_pkg::KIND_CHUNK:
                    if (!tx_end_seen)
                    begin
                        if (span < cur_window)
                        begin
                            res.action     = swsc_pkg::ACT_SEND;
                            res.seq_number = tx_next;
                            tx_next        = tx_next + 1'b1;
                        end
                        else
                            res.action = swsc_pkg::ACT_FULL;
                    end
                swsc_pkg::KIND_END:
                begin
                    tx_last     = tx_next - 1'b1;
                    tx_end_seen = 1'b1;
                end
                swsc_pkg::KIND_ACK:
                    if (tx_end_seen && ev.ack_number == tx_last)
                    begin
                        tx_done    = 1'b1;
                        tx_base    = new_base;
                        res.action = swsc_pkg::ACT_FIN;
                    end
                    else if (ev.ack_number == tx_last_ack)
                    begin
                        // duplicate: fire on reaching the limit, clamp above it
                        dups = tx_dups + 1'b1;
                        if (dups == cur_dup_limit)
                        begin
                            res.action     = swsc_pkg::ACT_RETX;
                            res.seq_number = new_base;
                        end
                        else if (dups > cur_dup_limit)
                            dups = cur_dup_limit;
                        tx_dups = dups[swsc_pkg::DUP_W-1:0];
                    end
                    else if (reach <= span)
                    begin
                        tx_base     = new_base;
                        tx_last_ack = ev.ack_number;
                        // count clears only when it sits at the limit
                        if (tx_dups == cur_dup_limit)
                            tx_dups = '0;
                    end
                swsc_pkg::KIND_TIMEOUT:
                begin
                    res.action     = swsc_pkg::ACT_RETX;
                    res.seq_number = tx_last_ack + 1'b1;
                end
            endcase
        end
        span = tx_next - tx_base;
        res.in_flight = (span > FLIGHT_MAX) ? FLIGHT_MAX[swsc_pkg::FLIGHT_W-1:0]
                                            : span[swsc_pkg::FLIGHT_W-1:0];
        return res;
    endfunction

    // Offer one event after a random gap, record its expected result on accept
    task automatic send_event(input swsc_pkg::kind_t kind,
                              input logic [swsc_pkg::ACK_W-1:0] ack);
        int                 gap;
        swsc_pkg::in_item_t ev;
        ev.kind       = kind;
        ev.ack_number = ack;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!in_ready);
        pending_actions.push_back(next_window_action(ev));
    endtask

    task automatic wait_results_drained();
        if (in_valid)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending_actions.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers (and optionally the unused index) with the unit idle
    task automatic program_registers(input logic [swsc_pkg::WIN_W-1:0] window,
                                     input logic [swsc_pkg::WIN_W-1:0] dup_word,
                                     input bit with_spare);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_index <= swsc_pkg::CFG_WINDOW_SIZE;
        cfg_data  <= window;
        do @(posedge clk); while (!cfg_ready);
        cur_window = window;
        if (with_spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= swsc_pkg::WIN_W'($urandom);
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_index <= swsc_pkg::CFG_DUP_THRESHOLD;
        cfg_data  <= dup_word;
        do @(posedge clk); while (!cfg_ready);
        cur_dup_limit = dup_word[swsc_pkg::DUP_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    // Result checker: random stalls, optional long hold-off, field compare
    initial
    begin : result_checker
        int                  stall;
        swsc_pkg::out_item_t got;
        swsc_pkg::out_item_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            else
                stall = $urandom_range(0, rx_stall_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got = out_data;
            if (pending_actions.size() == 0)
                report_mismatch($sformatf("unexpected result: action %0d seq %0d flight %0d",
                                          got.action, got.seq_number, got.in_flight));
            else
            begin
                want = pending_actions.pop_front();
                if (got.action !== want.action)
                    report_mismatch($sformatf("action %0d, expected %0d",
                                              got.action, want.action));
                if (got.seq_number !== want.seq_number)
                    report_mismatch($sformatf("seq_number %0d, expected %0d",
                                              got.seq_number, want.seq_number));
                if (got.in_flight !== want.in_flight)
                    report_mismatch($sformatf("in_flight %0d, expected %0d",
                                              got.in_flight, want.in_flight));
            end
        end
    end

    // Reset settings: idle timeout, initial duplicates, fill, duplicate-count quirk
    task automatic test_reset_defaults();
        send_event(swsc_pkg::KIND_TIMEOUT, 16'hFFFF);
        repeat (3) send_event(swsc_pkg::KIND_ACK, 16'hFFFF);
        send_event(swsc_pkg::KIND_ACK, 16'h0000);
        repeat (5) send_event(swsc_pkg::KIND_CHUNK, 16'h0000);
        send_event(swsc_pkg::KIND_ACK, 16'h0001);
        repeat (4) send_event(swsc_pkg::KIND_ACK, 16'h0001);
        send_event(swsc_pkg::KIND_ACK, 16'h5555);
        send_event(swsc_pkg::KIND_ACK, 16'hAAAA);
        send_event(swsc_pkg::KIND_ACK, 16'h0003);
        // count below the limit survives a new ACK
        send_event(swsc_pkg::KIND_ACK, 16'h0003);
        send_event(swsc_pkg::KIND_CHUNK, 16'hFFFF);
        send_event(swsc_pkg::KIND_ACK, 16'h0004);
        repeat (2) send_event(swsc_pkg::KIND_ACK, 16'h0004);
    endtask

    // Zero window, zero threshold, window of one, threshold of one
    task automatic test_config_extremes();
        program_registers(11'd0, 11'd0, 1'b1);
        send_event(swsc_pkg::KIND_CHUNK, 16'h0000);
        repeat (2) send_event(swsc_pkg::KIND_ACK, tx_last_ack);
        program_registers(11'd1, {7'h7F, 4'd1}, 1'b0);
        repeat (2) send_event(swsc_pkg::KIND_CHUNK, 16'h0000);
        send_event(swsc_pkg::KIND_ACK, tx_last_ack);
    endtask

    // Long result hold-off while events keep coming, then a full pause
    task automatic test_backpressure();
        program_registers(11'd16, 11'd3, 1'b0);
        rx_hold    = HOLD_CYCLES;
        tx_gap_max = 0;
        repeat (24)
        begin
            if ($urandom_range(0, 3) == 0)
                send_event(swsc_pkg::KIND_TIMEOUT, 16'($urandom));
            else
                send_event(swsc_pkg::KIND_CHUNK, 16'($urandom));
        end
        tx_gap_max = GAP_MAX;
        wait_results_drained();
        send_event(swsc_pkg::KIND_ACK, tx_next - 1'b1);
        repeat (4) send_event(swsc_pkg::KIND_CHUNK, 16'($urandom));
    endtask

    // Mostly well-formed traffic over several settings
    task automatic test_random_traffic();
        int unsigned                phase_window [PHASES];
        int unsigned                phase_dup [PHASES];
        int                         count;
        int                         pick;
        int                         burst;
        logic [swsc_pkg::SEQ_W-1:0] span;
        phase_window = '{1, 2, 4, 9, 33, 1024, 0, 0};
        phase_dup    = '{1, 0, 3, 15, 2, 7, 0, 0};
        phase_window[6] = $urandom_range(1, 1024);
        phase_window[7] = $urandom_range(1, 1024);
        phase_dup[6]    = $urandom_range(1, 15);
        phase_dup[7]    = $urandom_range(1, 15);
        for (int p = 0; p < PHASES; p++)
        begin
            program_registers(swsc_pkg::WIN_W'(phase_window[p]),
                              swsc_pkg::WIN_W'(($urandom_range(0, 127) << swsc_pkg::DUP_W)
                                               | phase_dup[p]),
                              1'b0);
            // some phases run back to back with no idling on either side
            tx_gap_max   = (p == 2 || p == 5) ? 0 : GAP_MAX;
            rx_stall_max = tx_gap_max;
            count = 0;
            while (count < RANDOM_ITEMS / PHASES)
            begin
                pick = $urandom_range(0, 99);
                span = tx_next - tx_base;
                if (pick < 40)
                    send_event(swsc_pkg::KIND_CHUNK, 16'($urandom));
                else if (pick < 65)
                    send_event(swsc_pkg::KIND_ACK,
                               tx_base - 1'b1 + 16'($urandom_range(0, span)));
                else if (pick < 80)
                begin
                    burst = $urandom_range(1, cur_dup_limit + 2);
                    repeat (burst) send_event(swsc_pkg::KIND_ACK, tx_last_ack);
                    count += burst - 1;
                end
                else if (pick < 90)
                    send_event(swsc_pkg::KIND_TIMEOUT, 16'($urandom));
                else
                    send_event(swsc_pkg::KIND_ACK, 16'($urandom));
                count++;
            end
        end
        tx_gap_max   = GAP_MAX;
        rx_stall_max = GAP_MAX;
    endtask

    // Largest window, a long run of sends with ACKs whenever it fills
    task automatic test_large_window();
        int                         sent;
        logic [swsc_pkg::SEQ_W-1:0] span;
        program_registers(11'd2047, 11'd15, 1'b0);
        sent = 0;
        while (sent < LONG_SENDS)
        begin
            span = tx_next - tx_base;
            if (span >= cur_window)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_event(swsc_pkg::KIND_CHUNK, 16'($urandom));
                send_event(swsc_pkg::KIND_ACK, tx_next - 1'b1 - 16'($urandom_range(0, 8)));
            end
            else
            begin
                send_event(swsc_pkg::KIND_CHUNK, 16'($urandom));
                sent++;
            end
        end
    endtask

    // Source end, late chunk, repeated end, finishing ACK, events after finish
    task automatic test_end_of_transfer();
        program_registers(11'd64, 11'd2, 1'b0);
        send_event(swsc_pkg::KIND_ACK, tx_next - 1'b1);
        repeat (10) send_event(swsc_pkg::KIND_CHUNK, 16'($urandom));
        send_event(swsc_pkg::KIND_END, 16'($urandom));
        send_event(swsc_pkg::KIND_CHUNK, 16'($urandom));
        send_event(swsc_pkg::KIND_ACK, tx_base + 1'b1);
        repeat (2) send_event(swsc_pkg::KIND_ACK, tx_last_ack);
        send_event(swsc_pkg::KIND_TIMEOUT, 16'($urandom));
        send_event(swsc_pkg::KIND_END, 16'($urandom));
        send_event(swsc_pkg::KIND_ACK, tx_last);
        send_event(swsc_pkg::KIND_CHUNK, 16'($urandom));
        send_event(swsc_pkg::KIND_END, 16'($urandom));
        send_event(swsc_pkg::KIND_ACK, tx_last);
        send_event(swsc_pkg::KIND_ACK, 16'($urandom));
        send_event(swsc_pkg::KIND_TIMEOUT, 16'($urandom));
    endtask

    initial
    begin
        reset_window_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        test_large_window();
        test_end_of_transfer();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_actions.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
